// ===== rtl/bfdh_pkg.sv =====
// bfdh_pkg: shared constants, register indexes and controller/datapath structs
// for the bloom filter block; no dependencies
`default_nettype none

package bfdh_pkg;

  localparam int unsigned MAX_BITS_DEF   = 65536;
  localparam int unsigned MAX_PROBES_DEF = 30;
  localparam int unsigned MIN_BITS       = 8;

  localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3, so the multiply is a shift plus a narrow product
  localparam int unsigned FNV_SHIFT      = 40;
  localparam logic [8:0]  FNV_PRIME_LOW  = 9'h1b3;

  localparam int unsigned HALF_W         = 32;
  localparam int unsigned DIV_STEPS      = HALF_W;

  localparam int unsigned BIT_COUNT_W    = 17;
  localparam int unsigned HASH_COUNT_W   = 5;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 17;

  localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd65536;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 2'd1;

  typedef struct packed {
    logic hash_upd;   // fold an accepted byte into the hash
    logic split;      // load both halves into the dividers, reset the hash
    logic mod_step;   // one restoring step of both dividers
    logic prep;       // first probe index and stride from the remainders
    logic probe;      // touch one filter bit and advance the index
    logic finish;     // load the result word
    logic clear;      // clear one filter bit after reset
  } cmd_t;

  typedef struct packed {
    logic [HASH_COUNT_W-1:0] probes;     // probe count in use
    logic                    clear_last; // clearing pass at its last bit
    logic                    out_busy;   // result word still waiting
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/bfdh_if.sv =====
// bfdh_if: valid/ready channels for key bytes, results and register writes
// depends on bfdh_pkg for the configuration field widths
`default_nettype none

interface bfdh_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;
  logic       command;
  modport source (output valid, key_byte, last_byte, command, input ready);
  modport sink   (input valid, key_byte, last_byte, command, output ready);
endinterface

interface bfdh_result_if;
  logic valid;
  logic ready;
  logic done_command;
  logic maybe_present;
  modport source (output valid, done_command, maybe_present, input ready);
  modport sink   (input valid, done_command, maybe_present, output ready);
endinterface

interface bfdh_cfg_if import bfdh_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfdh_ctrl.sv =====
// bfdh_ctrl: sequencer for clearing, hashing, modulo reduction and probing
// depends on bfdh_pkg for the command and status structs
`default_nettype none

module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  input  wire logic  out_take,
  input  wire stat_t stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SPLIT, S_DIVIDE, S_PREP, S_PROBE, S_DRAIN, S_FINISH
  } state_t;

  state_t state;
  logic [HASH_COUNT_W-1:0] cnt;
  logic out_free;

  assign out_free = !stat.out_busy || out_take;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.hash_upd = (state == S_IDLE) && in_valid;
    cmd.split    = (state == S_SPLIT);
    cmd.mod_step = (state == S_DIVIDE);
    cmd.prep     = (state == S_PREP);
    cmd.probe    = (state == S_PROBE);
    cmd.finish   = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (stat.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_last) state <= S_SPLIT;
        end
        S_SPLIT: begin
          cnt   <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (cnt == HASH_COUNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_PREP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PREP: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (cnt == stat.probes - 1'b1) state <= S_DRAIN;
          else cnt <= cnt + 1'b1;
        end
        // last read word lands here
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfdh_dpath.sv =====
// bfdh_dpath: hash register, bit-serial dividers, probe walker, filter store,
// configuration registers and result word; depends on bfdh_pkg
`default_nettype none

module bfdh_dpath
  import bfdh_pkg::*;
#(
  parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  input  wire logic [7:0]             key_byte,
  input  wire logic                   command,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   out_take,
  output stat_t                       stat,
  output logic                        out_valid,
  output logic                        done_command,
  output logic                        maybe_present
);

  localparam int unsigned IW = $clog2(MAX_BITS);
  localparam int unsigned MW = IW + 1;

  logic [63:0] hash;
  logic [63:0] hash_x;
  logic [63:0] hash_next;
  logic [BIT_COUNT_W-1:0]  bit_count;
  logic [HASH_COUNT_W-1:0] hash_count;
  logic [31:0] bc_wide;
  logic [31:0] mod_wide;
  logic [MW-1:0] modulus;
  logic cmd_q;
  logic [HALF_W-1:0] div_a, div_b;
  logic [IW-1:0] rem_a, rem_b;
  logic [MW-1:0] trial_a, trial_b;
  logic [IW-1:0] cur, stride;
  logic [MW-1:0] sum;
  logic [IW-1:0] clr_addr;
  logic mem [MAX_BITS];
  logic rd_data, rd_valid, all_set;
  logic mem_we, mem_wdata;
  logic [IW-1:0] mem_waddr;

  assign hash_x    = hash ^ {56'd0, key_byte};
  assign hash_next = (hash_x << FNV_SHIFT) + (hash_x * {55'd0, FNV_PRIME_LOW});

  // modulus and probe count held inside their legal ranges
  assign bc_wide  = 32'(bit_count);
  assign mod_wide = (bc_wide < 32'(MIN_BITS)) ? 32'(MIN_BITS) :
                    (bc_wide > 32'(MAX_BITS)) ? 32'(MAX_BITS) : bc_wide;

  always_comb begin
    stat            = '0;
    stat.clear_last = (clr_addr == IW'(MAX_BITS - 1));
    stat.out_busy   = out_valid;
    if (hash_count == '0) stat.probes = HASH_COUNT_W'(1);
    else if (hash_count > HASH_COUNT_W'(MAX_PROBES)) stat.probes = HASH_COUNT_W'(MAX_PROBES);
    else stat.probes = hash_count;
  end

  assign trial_a = {rem_a, div_a[HALF_W-1]};
  assign trial_b = {rem_b, div_b[HALF_W-1]};
  assign sum     = {1'b0, cur} + {1'b0, stride};

  assign mem_we    = cmd.clear || (cmd.probe && !cmd_q);
  assign mem_waddr = cmd.clear ? clr_addr : cur;
  assign mem_wdata = !cmd.clear;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.probe) rd_data <= mem[cur];
  end

  always_ff @(posedge clk) begin
    modulus <= MW'(mod_wide);
    if (cmd.hash_upd) cmd_q <= command;
    if (cmd.split) begin
      div_a <= hash[HALF_W-1:0];
      div_b <= hash[63:HALF_W];
      rem_a <= '0;
      rem_b <= '0;
    end
    if (cmd.mod_step) begin
      div_a <= div_a << 1;
      div_b <= div_b << 1;
      rem_a <= (trial_a >= modulus) ? IW'(trial_a - modulus) : trial_a[IW-1:0];
      rem_b <= (trial_b >= modulus) ? IW'(trial_b - modulus) : trial_b[IW-1:0];
    end
    if (cmd.prep) begin
      cur    <= rem_a;
      stride <= rem_b;
    end
    if (cmd.probe) cur <= (sum >= modulus) ? IW'(sum - modulus) : sum[IW-1:0];
    if (cmd.prep) all_set <= 1'b1;
    else if (rd_valid && !rd_data) all_set <= 1'b0;
    if (cmd.finish) begin
      done_command  <= cmd_q;
      maybe_present <= cmd_q ? all_set : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash       <= FNV_BASIS;
      bit_count  <= BIT_COUNT_RST;
      hash_count <= HASH_COUNT_RST;
      clr_addr   <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.split) hash <= FNV_BASIS;
      else if (cmd.hash_upd) hash <= hash_next;
      if (cfg_we && cfg_index == REG_BIT_COUNT) bit_count <= cfg_data[BIT_COUNT_W-1:0];
      if (cfg_we && cfg_index == REG_HASH_COUNT) hash_count <= cfg_data[HASH_COUNT_W-1:0];
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      rd_valid <= cmd.probe && cmd_q;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bloom_filter_fnv_double_hash_top.sv =====
// Bloom filter with FNV-1a 64-bit hashing and double-hashed probes: a byte
// that is not the last of its key leaves the block ready for the next. The
// last byte is hashed, the hash split, both halves reduced bit-serially
// modulo bit_count, the first index and stride set up, k probes made on the
// single-port filter store (k the probe count in use, hash_count held to
// 1..MAX_PROBES), the last read drained and the result word loaded (later
// if that word is still untaken); only then is the next byte accepted. After
// reset the store is cleared one bit a cycle and no key byte is accepted
// until that is done; register writes are taken at any time.
// depends on bfdh_pkg, bfdh_if, bfdh_ctrl and bfdh_dpath
`default_nettype none

module bloom_filter_fnv_double_hash_top
  import bfdh_pkg::*;
#(
  parameter int unsigned MAX_BITS   = MAX_BITS_DEF,
  parameter int unsigned MAX_PROBES = MAX_PROBES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  bfdh_key_if.sink      key_in,
  bfdh_result_if.source result,
  bfdh_cfg_if.sink      cfg
);

  cmd_t  cmd;
  stat_t stat;
  logic  out_take;
  logic  in_ready;

  assign out_take     = result.valid && result.ready;
  assign key_in.ready = in_ready;
  assign cfg.ready    = 1'b1;

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_last  (key_in.last_byte),
    .out_take (out_take),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bfdh_dpath #(
    .MAX_BITS   (MAX_BITS),
    .MAX_PROBES (MAX_PROBES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .key_byte      (key_in.key_byte),
    .command       (key_in.command),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_take      (out_take),
    .stat          (stat),
    .out_valid     (result.valid),
    .done_command  (result.done_command),
    .maybe_present (result.maybe_present)
  );

  // a last byte makes the block busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    key_in.valid && key_in.ready && key_in.last_byte |=> !key_in.ready)
    else $error("key accepted right after a last byte");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result.valid)
    else $error("result word not shown after finish");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.hash_upd, cmd.split, cmd.mod_step, cmd.prep, cmd.probe,
              cmd.finish, cmd.clear}))
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !result.valid || result.ready)
    else $error("result word overwritten");

endmodule

`default_nettype wire
